[rtl/alte_pkg.sv]
// ============================================================================
// alte_pkg
// Shared types and constants for the array list table engine.
// ============================================================================
package alte_pkg;

    localparam int DEPTH    = 32;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LIST    = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_SEARCH  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_SORT_UP = 3'd4,
        CMD_SORT_DN = 3'd5,
        CMD_LOCATE  = 3'd6,
        CMD_INVALID = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK          = 3'd0,
        STS_NOT_FOUND   = 3'd1,
        STS_FULL        = 3'd2,
        STS_BAD_INDEX   = 3'd3,
        STS_BAD_COMMAND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIST_REQ,
        ST_LIST_OUT,
        ST_SRCH_REQ,
        ST_SRCH_CMP,
        ST_DEL_CHK,
        ST_DEL_REQ,
        ST_DEL_WR,
        ST_SORT_LDI,
        ST_SORT_GETI,
        ST_SORT_REQJ,
        ST_SORT_CMP,
        ST_SORT_WBI,
        ST_LOC_REQ,
        ST_LOC_OUT,
        ST_EMIT
    } state_t;

endpackage

[rtl/alte_cmd_if.sv]
// ============================================================================
// alte_cmd_if
// Command request channel: valid/ready plus command payload.
// ============================================================================
interface alte_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [alte_pkg::CMD_W-1:0]            command;
    logic signed [alte_pkg::DATA_W-1:0]    value;
    logic [alte_pkg::INDEX_W-1:0]          index;

    modport source (output valid, output command, output value, output index, input ready);
    modport sink   (input valid, input command, input value, input index, output ready);
endinterface

[rtl/alte_rsp_if.sv]
// ============================================================================
// alte_rsp_if
// Result request channel: valid/ready plus result payload.
// ============================================================================
interface alte_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [alte_pkg::DATA_W-1:0]    item;
    logic [alte_pkg::DATA_W-1:0]           address;
    logic [alte_pkg::STATUS_W-1:0]         status;
    logic [alte_pkg::COUNT_W-1:0]          count;
    logic                                  last;

    modport source (output valid, output item, output address, output status,
                    output count, output last, input ready);
    modport sink   (input valid, input item, input address, input status,
                    input count, input last, output ready);
endinterface

[rtl/alte_ram.sv]
// ============================================================================
// alte_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/array_list_table_engine.sv]
// ============================================================================
// array_list_table_engine
// Packed list of signed 32-bit items with list/append/search/delete/sort/locate.
// ============================================================================
// Usage:
//   cmd  : command requests (command, value, index), valid/ready.
//   rsp  : result requests (item, address, status, count, last), valid/ready.
//   cfg_we/cfg_wdata : writes base_address; write only while idle.
// One command is handled at a time; cmd.ready is high only when the
// sequencer is idle and the result register is empty.
// All list storage sits in one RAM with one read and one write port; the
// sequencer walks the list one RAM access at a time, and the work per
// command follows list length n:
//   append : one write at slot n; bad command : no RAM access; locate : one read
//   search : reads items in order up to the first match or the end
//   delete : search, then each later item is shifted down one slot
//   sort   : for each slot in turn, hold its item and compare-swap it
//            with every later item, then write the held item back
//   list   : one result per item, last marked
// A stalled receiver holds the result register; a list walk pauses on it.
// Reset clears the count, base_address, state and result valid; RAM
// contents are not cleared (only slots below the count are ever read).
// ============================================================================
module array_list_table_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    alte_cmd_if.sink                      cmd,
    alte_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [alte_pkg::DATA_W-1:0]   cfg_wdata
);
    import alte_pkg::*;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [DATA_W-1:0]    base_reg;
    logic                 del_reg, del_next;     // delete vs. search
    logic                 desc_reg, desc_next;   // descending sort
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        jp_reg, jp_next;
    logic [DATA_W-1:0]    a_reg, a_next;         // held item during sort
    logic [DATA_W-1:0]    res_item_reg, res_item_next;
    logic [DATA_W-1:0]    res_addr_reg, res_addr_next;
    status_t              res_sts_reg, res_sts_next;

    logic                 ov_reg, ov_next;
    logic [DATA_W-1:0]    oitem_reg, oitem_next;
    logic [DATA_W-1:0]    oaddr_reg, oaddr_next;
    status_t              osts_reg, osts_next;
    logic [COUNT_W-1:0]   ocnt_reg, ocnt_next;
    logic                 olast_reg, olast_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [DATA_W-1:0]    mem_rdata;

    logic                 accept;
    logic                 swap;

    function automatic logic [DATA_W-1:0] addr_of(input logic [DATA_W-1:0] base,
                                                  input logic [CW-1:0] pos);
        addr_of = base + (DATA_W'(pos) << 2);
    endfunction

    alte_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd.ready   = (state_reg == ST_IDLE) && !ov_reg;
    assign accept      = cmd.valid && cmd.ready;
    assign rsp.valid   = ov_reg;
    assign rsp.item    = oitem_reg;
    assign rsp.address = oaddr_reg;
    assign rsp.status  = osts_reg;
    assign rsp.count   = ocnt_reg;
    assign rsp.last    = olast_reg;

    // the j side of the sort and the shift source use the second pointer
    assign mem_raddr = (state_reg == ST_SORT_REQJ || state_reg == ST_DEL_REQ) ?
                       jp_reg : ptr_reg;

    // sort compare: a signed compare per direction, selected by desc_reg
    assign swap = desc_reg ? ($signed(mem_rdata) > $signed(a_reg))
                           : ($signed(a_reg) > $signed(mem_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        del_reg      <= del_next;
        desc_reg     <= desc_next;
        val_reg      <= val_next;
        ptr_reg      <= ptr_next;
        jp_reg       <= jp_next;
        a_reg        <= a_next;
        res_item_reg <= res_item_next;
        res_addr_reg <= res_addr_next;
        res_sts_reg  <= res_sts_next;
        oitem_reg    <= oitem_next;
        oaddr_reg    <= oaddr_next;
        osts_reg     <= osts_next;
        ocnt_reg     <= ocnt_next;
        olast_reg    <= olast_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        del_next      = del_reg;
        desc_next     = desc_reg;
        val_next      = val_reg;
        ptr_next      = ptr_reg;
        jp_next       = jp_reg;
        a_next        = a_reg;
        res_item_next = res_item_reg;
        res_addr_next = res_addr_reg;
        res_sts_next  = res_sts_reg;
        ov_next       = ov_reg && !rsp.ready;
        oitem_next    = oitem_reg;
        oaddr_next    = oaddr_reg;
        osts_next     = osts_reg;
        ocnt_next     = ocnt_reg;
        olast_next    = olast_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = a_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_item_next = '0;
                    res_addr_next = '0;
                    res_sts_next  = STS_OK;
                    ptr_next      = '0;
                    val_next      = cmd.value;
                    del_next      = (cmd_t'(cmd.command) == CMD_DELETE);
                    desc_next     = (cmd_t'(cmd.command) == CMD_SORT_DN);
                    state_next    = ST_EMIT;
                    case (cmd_t'(cmd.command))
                        CMD_LIST:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_LIST_REQ;
                            end
                        end
                        CMD_APPEND:
                        begin
                            res_item_next = cmd.value;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                res_sts_next = STS_FULL;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = count_reg[AW-1:0];
                                mem_wdata     = cmd.value;
                                count_next    = count_reg + CW'(1);
                                res_addr_next = addr_of(base_reg, count_reg + CW'(1));
                            end
                        end
                        CMD_SEARCH, CMD_DELETE:
                        begin
                            res_item_next = cmd.value;
                            if (count_reg == '0)
                            begin
                                res_sts_next = STS_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = ST_SRCH_REQ;
                            end
                        end
                        CMD_SORT_UP, CMD_SORT_DN:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                state_next = ST_SORT_LDI;
                            end
                        end
                        CMD_LOCATE:
                        begin
                            if (cmd.index == '0 || cmd.index > COUNT_W'(count_reg))
                            begin
                                res_sts_next = STS_BAD_INDEX;
                            end
                            else
                            begin
                                ptr_next      = AW'(cmd.index - INDEX_W'(1));
                                res_addr_next = addr_of(base_reg, CW'(cmd.index));
                                state_next    = ST_LOC_REQ;
                            end
                        end
                        default:
                        begin
                            res_sts_next = STS_BAD_COMMAND;
                        end
                    endcase
                end
            end
            ST_LIST_REQ:
            begin
                state_next = ST_LIST_OUT;
            end
            ST_LIST_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oitem_next = mem_rdata;
                    oaddr_next = addr_of(base_reg, CW'(ptr_reg) + CW'(1));
                    osts_next  = STS_OK;
                    ocnt_next  = COUNT_W'(count_reg);
                    olast_next = (CW'(ptr_reg) + CW'(1) == count_reg);
                    if (CW'(ptr_reg) + CW'(1) == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = ST_LIST_REQ;
                    end
                end
            end
            ST_SRCH_REQ:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    res_addr_next = addr_of(base_reg, CW'(ptr_reg) + CW'(1));
                    state_next    = del_reg ? ST_DEL_CHK : ST_EMIT;
                end
                else if (CW'(ptr_reg) + CW'(1) == count_reg)
                begin
                    res_sts_next = STS_NOT_FOUND;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    ptr_next   = ptr_reg + AW'(1);
                    state_next = ST_SRCH_REQ;
                end
            end
            ST_DEL_CHK:
            begin
                if (CW'(ptr_reg) + CW'(1) < count_reg)
                begin
                    jp_next    = ptr_reg + AW'(1);
                    state_next = ST_DEL_REQ;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_EMIT;
                end
            end
            ST_DEL_REQ:
            begin
                state_next = ST_DEL_WR;
            end
            ST_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = mem_rdata;
                ptr_next   = jp_reg;
                state_next = ST_DEL_CHK;
            end
            ST_SORT_LDI:
            begin
                state_next = ST_SORT_GETI;
            end
            ST_SORT_GETI:
            begin
                a_next     = mem_rdata;
                jp_next    = ptr_reg + AW'(1);
                state_next = ST_SORT_REQJ;
            end
            ST_SORT_REQJ:
            begin
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (swap)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = jp_reg;
                    mem_wdata = a_reg;
                    a_next    = mem_rdata;
                end
                if (CW'(jp_reg) + CW'(1) == count_reg)
                begin
                    state_next = ST_SORT_WBI;
                end
                else
                begin
                    jp_next    = jp_reg + AW'(1);
                    state_next = ST_SORT_REQJ;
                end
            end
            ST_SORT_WBI:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = a_reg;
                if (CW'(ptr_reg) + CW'(2) < count_reg)
                begin
                    ptr_next   = ptr_reg + AW'(1);
                    state_next = ST_SORT_LDI;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LOC_REQ:
            begin
                state_next = ST_LOC_OUT;
            end
            ST_LOC_OUT:
            begin
                res_item_next = mem_rdata;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                // result register is known empty here: ready required it
                ov_next    = 1'b1;
                oitem_next = res_item_reg;
                oaddr_next = res_addr_reg;
                osts_next  = res_sts_reg;
                ocnt_next  = COUNT_W'(count_reg);
                olast_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("item count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("item count moved by more than one");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) <= count_reg))
        else $error("RAM write beyond the packed list");

    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !ov_reg)
        else $error("result overwritten before it was taken");
`endif

endmodule
